// ===== design/lz77_pkg.sv =====
// Package for the LZ77 triplet encoder: store sizes and field widths.
// No dependencies.
package lz77_pkg;
   localparam int WINDOW_MAX  = 16;
   localparam int STORE_DEPTH = 2 * WINDOW_MAX;
   localparam int IDX_W       = $clog2(STORE_DEPTH);
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
   localparam int WIN_W       = 5;
   localparam int OFF_W       = 5;
   localparam int LEN_W       = 4;
endpackage

// ===== design/lz77_triplet_encoder.sv =====
// LZ77 triplet encoder top level: byte store, candidate search sequencer and result register.
// Depends on lz77_pkg.
//
// Channel | Direction | Payload
// req     | in        | tdata[7:0] = data_byte, tlast = end_of_input
// rsp     | out       | tdata[4:0] offset, [8:5] length, [16:9] next_byte, [17] has_next;
//         |           | tlast = last_token
// csr     | in        | wdata[4:0] = window_size
//
// An item that decides no triplet goes through the accept and one check.
// Each triplet adds a check, a search over every history candidate (up to the window
// size) with a closing step, an issue, and a shift that drops the history bytes that
// fall out of the window, all through a single compare unit.
// Synchronous reset clears the hist and pend counters and sequencer; the store needs none.
// A stalled result holds the sequencer in the issue state; no item is taken until
// all triplets of the previous item are issued.
module lz77_triplet_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tlast,   // end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // match_offset, match_length, next_byte, has_next
   output logic        rsp_tlast,   // last_token
   input  logic        csr_we,
   input  logic [4:0]  csr_wdata    // window_size
);
   import lz77_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_SRCH  = 3'd2;
   localparam logic [2:0] ST_EMIT  = 3'd3;
   localparam logic [2:0] ST_SHIFT = 3'd5;

   logic [7:0]       store_ff [STORE_DEPTH];
   logic [CNT_W-1:0] hist_ff, hist_in, pend_ff, pend_in;
   logic [WIN_W-1:0] win_ff, win_in;
   logic [2:0]       state_ff, state_in;
   logic             end_ff, end_in;
   logic [CNT_W-1:0] d_ff, d_in, shift_ff, shift_in;
   logic [CNT_W-1:0] blen_ff, blen_in, boff_ff, boff_in;
   logic             ovalid_ff, ovalid_in;
   logic [23:0]      odata_ff, odata_in;
   logic             olast_ff, olast_in;

   logic [CNT_W-1:0] weff, look, cap, avail, k, used, total, keep;
   logic [CNT_W:0]   pos;
   logic [STORE_DEPTH-1:0] eq, run;
   logic             has, do_shift;
   logic [7:0]       nb;

   always_comb begin
      weff  = (win_ff > WIN_W'(WINDOW_MAX)) ? CNT_W'(WINDOW_MAX) : CNT_W'(win_ff);
      look  = (weff == '0) ? CNT_W'(1) : weff;
      cap   = look - CNT_W'(1);
      avail = (hist_ff < weff) ? hist_ff : weff;
      pos   = (CNT_W+1)'(hist_ff) + (CNT_W+1)'(pend_ff);
      // Shared comparator row: candidate at distance d_ff against lookahead.
      for (int i = 0; i < STORE_DEPTH; i++) begin
         if ((CNT_W+1)'(hist_ff) + (CNT_W+1)'(i) < (CNT_W+1)'(STORE_DEPTH)
             && (CNT_W+1)'(hist_ff) + (CNT_W+1)'(i) >= (CNT_W+1)'(d_ff))
            eq[i] = store_ff[IDX_W'(hist_ff - d_ff + CNT_W'(i))]
                    == store_ff[IDX_W'(hist_ff + CNT_W'(i))];
         else
            eq[i] = 1'b0;
      end
      for (int i = 0; i < STORE_DEPTH; i++) begin
         run[i] = CNT_W'(i) < d_ff && CNT_W'(i) < cap && CNT_W'(i) < pend_ff && eq[i];
      end
      k = CNT_W'(STORE_DEPTH);
      for (int i = STORE_DEPTH - 1; i >= 0; i--) begin
         if (!run[i])
            k = CNT_W'(i);
      end
      has   = blen_ff < pend_ff;
      nb    = (has && (CNT_W+1)'(hist_ff) + (CNT_W+1)'(blen_ff) < (CNT_W+1)'(STORE_DEPTH))
              ? store_ff[IDX_W'(hist_ff + blen_ff)] : 8'd0;
      used  = blen_ff + (has ? CNT_W'(1) : CNT_W'(0));
      total = hist_ff + used;
      keep  = (total < weff) ? total : weff;
   end

   always_comb begin
      state_in  = state_ff;
      hist_in   = hist_ff;
      pend_in   = pend_ff;
      win_in    = csr_we ? csr_wdata : win_ff;
      end_in    = end_ff;
      d_in      = d_ff;
      shift_in  = shift_ff;
      blen_in   = blen_ff;
      boff_in   = boff_ff;
      ovalid_in = ovalid_ff;
      odata_in  = odata_ff;
      olast_in  = olast_ff;
      do_shift  = 1'b0;
      req_tready = (state_ff == ST_IDLE);
      if (ovalid_ff && rsp_tready) begin
         ovalid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               end_in = req_tlast;
               if (pos < (CNT_W+1)'(STORE_DEPTH)) begin
                  pend_in = pend_ff + CNT_W'(1);
               end
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (pend_ff != '0 && (end_ff || pend_ff >= look)) begin
               d_in     = avail;
               blen_in  = '0;
               boff_in  = '0;
               state_in = ST_SRCH;
            end else begin
               if (end_ff) begin
                  hist_in = '0;
                  pend_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         ST_SRCH: begin
            if (d_ff == '0) begin
               state_in = ST_EMIT;
            end else begin
               if (k > blen_ff) begin
                  blen_in = k;
                  boff_in = d_ff;
               end
               d_in = d_ff - CNT_W'(1);
            end
         end
         ST_EMIT: begin
            if (!ovalid_ff || rsp_tready) begin
               ovalid_in = 1'b1;
               odata_in  = {6'd0, has, nb, LEN_W'(blen_ff), OFF_W'(boff_ff)};
               olast_in  = end_ff && (used == pend_ff);
               shift_in  = total - keep;
               hist_in   = keep;
               pend_in   = pend_ff - used;
               state_in  = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (shift_ff == '0) begin
               state_in = ST_CHECK;
            end else begin
               do_shift = 1'b1;
               shift_in = shift_ff - CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_tvalid && pos < (CNT_W+1)'(STORE_DEPTH)) begin
         store_ff[IDX_W'(pos)] <= req_tdata;
      end else if (do_shift) begin
         for (int i = 0; i < STORE_DEPTH - 1; i++) begin
            store_ff[i] <= store_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         hist_ff   <= '0;
         pend_ff   <= '0;
         win_ff    <= WIN_W'(16);
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         hist_ff   <= hist_in;
         pend_ff   <= pend_in;
         win_ff    <= win_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      end_ff   <= end_in;
      d_ff     <= d_in;
      shift_ff <= shift_in;
      blen_ff  <= blen_in;
      boff_ff  <= boff_in;
      odata_ff <= odata_in;
      olast_ff <= olast_in;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tlast  = olast_ff;
endmodule
